// ===== design/sphere_vertex_generator_core_assert.svh =====
// Assertion macros shared by the sphere vertex generator RTL.
`ifndef SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define SVGC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define SVGC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/svg_pkg.sv =====
// Package with constants, types and tables of the sphere vertex generator.
package svg_pkg;

    localparam int MAX_COUNT_DEF    = 1024;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    // Configuration port.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_SECTORS = 2'd1;
    localparam logic [CFG_AW-1:0] REG_STACKS  = 2'd2;

    localparam logic [15:0] RADIUS_RESET = 16'd256;
    localparam logic [10:0] SECTOR_RESET = 11'd36;
    localparam logic [10:0] STACK_RESET  = 11'd18;

    // Quadrant codes of a phase.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Rotator fixed point: Q30 values in a 34-bit signed word.
    localparam int RW = 34;
    localparam logic signed [RW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic [32:0]          PI_Q30       = 33'd3373259426;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
        logic [1:0]           quad;
    } rot_t;

    typedef struct packed {
        logic [16:0] tex_s;
        logic [16:0] tex_t;
        logic        clamped;
    } side_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [RW-1:0] atan_q30(input int unsigned i);
        case (i)
            0:       return 34'sd843314857;
            1:       return 34'sd497837829;
            2:       return 34'sd263043837;
            3:       return 34'sd133525159;
            4:       return 34'sd67021687;
            5:       return 34'sd33543516;
            6:       return 34'sd16775851;
            7:       return 34'sd8388437;
            8:       return 34'sd4194283;
            9:       return 34'sd2097149;
            10:      return 34'sd1048576;
            11:      return 34'sd524288;
            12:      return 34'sd262144;
            13:      return 34'sd131072;
            14:      return 34'sd65536;
            15:      return 34'sd32768;
            16:      return 34'sd16384;
            17:      return 34'sd8192;
            18:      return 34'sd4096;
            19:      return 34'sd2048;
            20:      return 34'sd1024;
            21:      return 34'sd512;
            22:      return 34'sd256;
            23:      return 34'sd128;
            default: return '0;
        endcase
    endfunction

endpackage

// ===== design/sphere_vertex_generator_core.sv =====
// Sphere vertex generator: grid point in, position, normal and texture coordinates out.
//
// The slave stream carries one grid point per transfer (stack row, sector column).
// The master stream returns one vertex per transfer: position in Q8.8, unit normal
// in Q1.14, texture coordinates in Q1.16, and tuser set when an index was clamped.
// The user must write radius and the two division counts through the cfg_* port only
// while no vertex is in flight; the block does not enforce this. cfg_addr 3 is ignored.
// Throughput is one vertex per cycle while the output is not stalled. The pipe has
// one input stage, eight long-division stages of four quotient bits each, a phase
// stage, an angle multiply stage, one stage per CORDIC iteration (CORDIC_STEPS capped
// at 24), then quadrant, product, radius and output stages.
// All stages advance together; when the receiver holds m_axis_tready low with a
// vertex waiting, the whole pipe freezes and s_axis_tready drops, so nothing is lost
// or repeated. Bubbles in the pipe are not squeezed out; while the output register is
// empty, the pipe advances even with m_axis_tready low.
// Synchronous active-low reset clears the pipeline valid bits and loads radius 256,
// 36 sectors and 18 stacks.
module sphere_vertex_generator_core
    import svg_pkg::*;
#(
    parameter int MAX_COUNT    = MAX_COUNT_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration writes.
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wr_data,
    // Grid point stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // stack_row[10:0], sector_column[21:11]
    // Vertex stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // pos_x[16:0], pos_y[33:17], pos_z[50:34], norm_x[66:51], norm_y[82:67],
    // norm_z[98:83], tex_s[115:99], tex_t[132:116]
    output logic [135:0]      m_axis_tdata,
    output logic              m_axis_tuser    // index_clamped
);

    localparam int CW       = $clog2(MAX_COUNT + 1);
    localparam int NC       = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int DIV_BITS = 4;
    localparam int DIV_ST   = 32 / DIV_BITS;
    localparam int ST_PH    = DIV_ST + 1;
    localparam int ST_QD    = DIV_ST + 3 + NC;
    localparam int NSTG     = ST_QD + 4;
    localparam int SB_N     = NSTG - ST_PH;

    // Long-division step group: DIV_BITS restoring steps on a remainder below d.
    function automatic logic [CW+DIV_BITS-1:0] div_step(input logic [CW-1:0] rem_in,
                                                        input logic [CW-1:0] d);
        logic [CW:0]         r2;
        logic [CW-1:0]       rem;
        logic [DIV_BITS-1:0] bits;
        rem  = rem_in;
        bits = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            r2 = {rem, 1'b0};
            if (r2 >= {1'b0, d}) begin
                bits = {bits[DIV_BITS-2:0], 1'b1};
                rem  = CW'(r2 - {1'b0, d});
            end else begin
                bits = {bits[DIV_BITS-2:0], 1'b0};
                rem  = r2[CW-1:0];
            end
        end
        return {rem, bits};
    endfunction

    // Quadrant and signed residual of a phase in 2^-32 turn units.
    function automatic logic [31:0] split_phase(input logic [31:0] ph);
        logic [31:0] sum;
        logic [31:0] rr;
        sum = ph + 32'h2000_0000;
        rr  = ph - {sum[31:30], 30'd0};
        return {sum[31:30], rr[29:0]};
    endfunction

    // One CORDIC rotation-mode iteration.
    function automatic rot_t rot_step(input rot_t a, input int unsigned i);
        rot_t                 b;
        logic signed [RW-1:0] dx;
        logic signed [RW-1:0] dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        b.quad = a.quad;
        if (!a.z[RW-1]) begin
            b.x = a.x - dx;
            b.y = a.y + dy;
            b.z = a.z - atan_q30(i);
        end else begin
            b.x = a.x + dx;
            b.y = a.y - dy;
            b.z = a.z + atan_q30(i);
        end
        return b;
    endfunction

    // Rounded Q30 angle from a residual phase.
    function automatic logic signed [RW-1:0] resid_to_rad(input logic signed [29:0] r);
        logic signed [63:0] p;
        p = r * $signed({1'b0, PI_Q30});
        p = p + (64'sd1 <<< 30);
        p = p >>> 31;
        return p[RW-1:0];
    endfunction

    // Rounded Q30 product of two Q30 values.
    function automatic logic signed [RW-1:0] mul_q30(input logic signed [RW-1:0] a,
                                                     input logic signed [RW-1:0] b);
        logic signed [31:0] a32;
        logic signed [31:0] b32;
        logic signed [63:0] p;
        a32 = a[31:0];
        b32 = b[31:0];
        p   = a32 * b32;
        p   = p + (64'sd1 <<< 29);
        p   = p >>> 30;
        return p[RW-1:0];
    endfunction

    function automatic logic [16:0] pos_sat(input logic signed [50:0] p);
        logic signed [50:0] t;
        t = (p + (51'sd1 <<< 29)) >>> 30;
        if (t > 51'sd65535) begin
            return 17'h0FFFF;
        end else if (t < -51'sd65535) begin
            return 17'h10001;
        end
        return t[16:0];
    endfunction

    function automatic logic [15:0] norm_sat(input logic signed [RW-1:0] n);
        logic signed [RW-1:0] t;
        t = (n + (34'sd1 <<< 15)) >>> 16;
        if (t > 34'sd16384) begin
            return 16'h4000;
        end else if (t < -34'sd16384) begin
            return 16'hC000;
        end
        return t[15:0];
    endfunction

    logic [15:0]     radius_reg;
    logic [10:0]     sector_total_reg;
    logic [10:0]     stack_total_reg;
    logic [CW-1:0]   sect_cnt;
    logic [CW-1:0]   stack_cnt;
    logic [NSTG-1:0] vld_reg;
    logic            en;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg       <= RADIUS_RESET;
            sector_total_reg <= SECTOR_RESET;
            stack_total_reg  <= STACK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RADIUS:  radius_reg       <= cfg_wr_data;
                REG_SECTORS: sector_total_reg <= cfg_wr_data[10:0];
                REG_STACKS:  stack_total_reg  <= cfg_wr_data[10:0];
                default: ;
            endcase
        end
    end

    // Counts in use, saturated to their legal ranges.
    always_comb begin
        if (sector_total_reg < 11'd3) begin
            sect_cnt = CW'(3);
        end else if (32'(sector_total_reg) > 32'(MAX_COUNT)) begin
            sect_cnt = CW'(MAX_COUNT);
        end else begin
            sect_cnt = CW'(sector_total_reg);
        end
        if (stack_total_reg < 11'd2) begin
            stack_cnt = CW'(2);
        end else if (32'(stack_total_reg) > 32'(MAX_COUNT)) begin
            stack_cnt = CW'(MAX_COUNT);
        end else begin
            stack_cnt = CW'(stack_total_reg);
        end
    end

    // The whole pipe moves unless a finished vertex waits at the output.
    assign en            = !vld_reg[NSTG-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_axis_tvalid};
        end
    end

    // Index clamping at the input.
    logic [10:0]   row_in;
    logic [10:0]   col_in;
    logic          row_over;
    logic          col_over;
    logic [CW-1:0] row_cl;
    logic [CW-1:0] col_cl;

    assign row_in   = s_axis_tdata[10:0];
    assign col_in   = s_axis_tdata[21:11];
    assign row_over = 32'(row_in) > 32'(stack_cnt);
    assign col_over = 32'(col_in) > 32'(sect_cnt);
    assign row_cl   = row_over ? stack_cnt : CW'(row_in);
    assign col_cl   = col_over ? sect_cnt : CW'(col_in);

    // Long division of index by count: an integer bit and 32 fraction bits.
    logic [CW-1:0] dv_rem_r_reg [DIV_ST+1];
    logic [CW-1:0] dv_rem_c_reg [DIV_ST+1];
    logic [31:0]   dv_q_r_reg   [DIV_ST+1];
    logic [31:0]   dv_q_c_reg   [DIV_ST+1];
    logic          dv_int_r_reg [DIV_ST+1];
    logic          dv_int_c_reg [DIV_ST+1];
    logic          dv_flag_reg  [DIV_ST+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_int_r_reg[0] <= (row_cl == stack_cnt);
            dv_int_c_reg[0] <= (col_cl == sect_cnt);
            dv_rem_r_reg[0] <= (row_cl == stack_cnt) ? '0 : row_cl;
            dv_rem_c_reg[0] <= (col_cl == sect_cnt) ? '0 : col_cl;
            dv_q_r_reg[0]   <= '0;
            dv_q_c_reg[0]   <= '0;
            dv_flag_reg[0]  <= row_over || col_over;
        end
    end

    for (genvar g = 0; g < DIV_ST; g++) begin : g_div
        logic [CW+DIV_BITS-1:0] st_r;
        logic [CW+DIV_BITS-1:0] st_c;
        assign st_r = div_step(dv_rem_r_reg[g], stack_cnt);
        assign st_c = div_step(dv_rem_c_reg[g], sect_cnt);
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_r_reg[g+1] <= st_r[CW+DIV_BITS-1:DIV_BITS];
                dv_rem_c_reg[g+1] <= st_c[CW+DIV_BITS-1:DIV_BITS];
                dv_q_r_reg[g+1]   <= {dv_q_r_reg[g][31-DIV_BITS:0], st_r[DIV_BITS-1:0]};
                dv_q_c_reg[g+1]   <= {dv_q_c_reg[g][31-DIV_BITS:0], st_c[DIV_BITS-1:0]};
                dv_int_r_reg[g+1] <= dv_int_r_reg[g];
                dv_int_c_reg[g+1] <= dv_int_c_reg[g];
                dv_flag_reg[g+1]  <= dv_flag_reg[g];
            end
        end
    end

    // Phases, quadrants and texture coordinates.
    logic [31:0]        q_r_fin;
    logic [31:0]        q_c_fin;
    logic [31:0]        ph_stk;
    logic [31:0]        sp_stk;
    logic [31:0]        sp_sec;
    logic [1:0]         ph_q_stk_reg;
    logic [1:0]         ph_q_sec_reg;
    logic signed [29:0] ph_r_stk_reg;
    logic signed [29:0] ph_r_sec_reg;
    side_t              sb_reg [SB_N];

    assign q_r_fin = dv_q_r_reg[DIV_ST];
    assign q_c_fin = dv_q_c_reg[DIV_ST];
    assign ph_stk  = 32'h4000_0000 - {dv_int_r_reg[DIV_ST], q_r_fin[31:1]};
    assign sp_stk  = split_phase(ph_stk);
    assign sp_sec  = split_phase(q_c_fin);

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_q_stk_reg     <= sp_stk[31:30];
            ph_r_stk_reg     <= sp_stk[29:0];
            ph_q_sec_reg     <= sp_sec[31:30];
            ph_r_sec_reg     <= sp_sec[29:0];
            sb_reg[0].tex_s  <= {dv_int_c_reg[DIV_ST], q_c_fin[31:16]} + 17'(q_c_fin[15]);
            sb_reg[0].tex_t  <= {dv_int_r_reg[DIV_ST], q_r_fin[31:16]} + 17'(q_r_fin[15]);
            sb_reg[0].clamped <= dv_flag_reg[DIV_ST];
        end
    end

    // Texture coordinates and flag ride along with the angle path.
    for (genvar g = 1; g < SB_N; g++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                sb_reg[g] <= sb_reg[g-1];
            end
        end
    end

    // Residual to radians, then the CORDIC iterations.
    rot_t cr_stk_reg [NC+1];
    rot_t cr_sec_reg [NC+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            cr_stk_reg[0] <= '{x: INV_GAIN_Q30, y: '0, z: resid_to_rad(ph_r_stk_reg),
                               quad: ph_q_stk_reg};
            cr_sec_reg[0] <= '{x: INV_GAIN_Q30, y: '0, z: resid_to_rad(ph_r_sec_reg),
                               quad: ph_q_sec_reg};
        end
    end

    for (genvar g = 0; g < NC; g++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                cr_stk_reg[g+1] <= rot_step(cr_stk_reg[g], g);
                cr_sec_reg[g+1] <= rot_step(cr_sec_reg[g], g);
            end
        end
    end

    // Quadrant correction.
    logic signed [RW-1:0] cs_next;
    logic signed [RW-1:0] ss_next;
    logic signed [RW-1:0] ca_next;
    logic signed [RW-1:0] sa_next;
    logic signed [RW-1:0] cs_reg;
    logic signed [RW-1:0] ss_reg;
    logic signed [RW-1:0] ca_reg;
    logic signed [RW-1:0] sa_reg;
    rot_t                 fs;
    rot_t                 fa;

    assign fs = cr_stk_reg[NC];
    assign fa = cr_sec_reg[NC];

    always_comb begin
        case (fs.quad)
            QUAD_0:  begin cs_next = fs.x;  ss_next = fs.y;  end
            QUAD_1:  begin cs_next = -fs.y; ss_next = fs.x;  end
            QUAD_2:  begin cs_next = -fs.x; ss_next = -fs.y; end
            default: begin cs_next = fs.y;  ss_next = -fs.x; end
        endcase
        case (fa.quad)
            QUAD_0:  begin ca_next = fa.x;  sa_next = fa.y;  end
            QUAD_1:  begin ca_next = -fa.y; sa_next = fa.x;  end
            QUAD_2:  begin ca_next = -fa.x; sa_next = -fa.y; end
            default: begin ca_next = fa.y;  sa_next = -fa.x; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cs_reg <= cs_next;
            ss_reg <= ss_next;
            ca_reg <= ca_next;
            sa_reg <= sa_next;
        end
    end

    // Normal vector in Q30.
    logic signed [RW-1:0] np_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            np_reg[0] <= mul_q30(cs_reg, ca_reg);
            np_reg[1] <= mul_q30(cs_reg, sa_reg);
            np_reg[2] <= ss_reg;
        end
    end

    // Scale by the radius; keep the normal alongside.
    logic signed [50:0]   rp_reg [3];
    logic signed [RW-1:0] nk_reg [3];

    for (genvar k = 0; k < 3; k++) begin : g_scale
        always_ff @(posedge aclk) begin
            if (en) begin
                rp_reg[k] <= $signed({1'b0, radius_reg}) * np_reg[k];
                nk_reg[k] <= np_reg[k];
            end
        end
    end

    // Output register: round and saturate.
    logic [16:0] pos_reg  [3];
    logic [15:0] norm_reg [3];

    for (genvar k = 0; k < 3; k++) begin : g_out
        always_ff @(posedge aclk) begin
            if (en) begin
                pos_reg[k]  <= pos_sat(rp_reg[k]);
                norm_reg[k] <= norm_sat(nk_reg[k]);
            end
        end
    end

    assign m_axis_tdata = {3'd0, sb_reg[SB_N-1].tex_t, sb_reg[SB_N-1].tex_s,
                           norm_reg[2], norm_reg[1], norm_reg[0],
                           pos_reg[2], pos_reg[1], pos_reg[0]};
    assign m_axis_tuser = sb_reg[SB_N-1].clamped;

    `include "sphere_vertex_generator_core_assert.svh"

    `SVGC_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_reg[0], "accepted transfer did not enter the pipe")
    `SVGC_ASSERT_NXT(a_stall_freezes, !en, $stable(vld_reg), "pipe moved while stalled")
    `SVGC_ASSERT_IMP(a_norm_range, m_axis_tvalid, ($signed(norm_reg[2]) <= 16'sd16384) && ($signed(norm_reg[2]) >= -16'sd16384), "normal z out of range")
    `SVGC_ASSERT_IMP(a_tex_range, m_axis_tvalid, (sb_reg[SB_N-1].tex_s <= 17'd65536) && (sb_reg[SB_N-1].tex_t <= 17'd65536), "texture coordinate above one")

endmodule

// ===== test/sphere_vertex_generator_core_test.sv =====
// Self-checking testbench for the sphere vertex generator core.
`timescale 1ns / 100ps

module sphere_vertex_generator_core_test;
    import svg_pkg::*;

    localparam int LATENCY  = 40;
    localparam int WDOG_MAX = 20000;

    // Register index that the core ignores.
    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [16:0] pos_x, pos_y, pos_z;
        logic [15:0] norm_x, norm_y, norm_z;
        logic [16:0] tex_s, tex_t;
        logic        clamped;
    } vertex_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [135:0]      m_axis_tdata;
    logic              m_axis_tuser;

    // Predictor copy of the registers.
    logic [15:0] radius_q = RADIUS_RESET;
    logic [10:0] sectors_q = SECTOR_RESET;
    logic [10:0] stacks_q = STACK_RESET;

    vertex_t vertex_queue[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      stall_free = 1'b0;

    sphere_vertex_generator_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint shr_floor(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint shr_round(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint arctan_q30(int i);
        longint tbl[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128};
        return tbl[i];
    endfunction

    // Cosine and sine of a phase in 2^-32 turns, both Q30.
    task automatic phase_cos_sin(input logic [31:0] phase, output longint c,
                                 output longint s);
        logic [31:0] quad;
        logic [31:0] resid;
        longint r, z, x, y, dx, dy;
        quad = ((phase + 32'h2000_0000) >> 30) & 32'd3;
        resid = phase - (quad << 30);
        r = longint'($signed(resid));
        z = shr_round(r * longint'(PI_Q30), 31);
        x = INV_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_q30(i);
            end else begin
                x += dx; y -= dy; z += arctan_q30(i);
            end
        end
        case (quad[1:0])
            QUAD_0: begin c = x; s = y; end
            QUAD_1: begin c = -y; s = x; end
            QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // Expected vertex for one grid point under the current registers.
    task automatic predict_vertex(input logic [10:0] row_in, input logic [10:0] col_in,
                                  output vertex_t v);
        longint unsigned sectors, stacks, row, col;
        logic [31:0] ph_sector, ph_stack;
        longint cs, ss, ca, sa, p, m;
        longint n[3];
        sectors = limit(sectors_q, 3, MAX_COUNT_DEF);
        stacks = limit(stacks_q, 2, MAX_COUNT_DEF);
        row = row_in;
        col = col_in;
        v.clamped = 1'b0;
        if (row > stacks) begin row = stacks; v.clamped = 1'b1; end
        if (col > sectors) begin col = sectors; v.clamped = 1'b1; end
        ph_sector = 32'((col << 32) / sectors);
        ph_stack = 32'h4000_0000 - 32'((row << 31) / stacks);
        phase_cos_sin(ph_stack, cs, ss);
        phase_cos_sin(ph_sector, ca, sa);
        n[0] = shr_round(cs * ca, 30);
        n[1] = shr_round(cs * sa, 30);
        n[2] = ss;
        p = limit(shr_round(longint'(radius_q) * n[0], 30), -65535, 65535);
        v.pos_x = p[16:0];
        p = limit(shr_round(longint'(radius_q) * n[1], 30), -65535, 65535);
        v.pos_y = p[16:0];
        p = limit(shr_round(longint'(radius_q) * n[2], 30), -65535, 65535);
        v.pos_z = p[16:0];
        m = limit(shr_round(n[0], 16), -16384, 16384);
        v.norm_x = m[15:0];
        m = limit(shr_round(n[1], 16), -16384, 16384);
        v.norm_y = m[15:0];
        m = limit(shr_round(n[2], 16), -16384, 16384);
        v.norm_z = m[15:0];
        v.tex_s = 17'((col * 131072 + sectors) / (2 * sectors));
        v.tex_t = 17'((row * 131072 + stacks) / (2 * stacks));
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Appends one expected vertex at the tail of the queue.
    task automatic store_expected(input vertex_t v);
        vertex_queue.insert(vertex_queue.size(), v);
    endtask

    // Sends one grid point after a random gap and queues its expected vertex.
    // tvalid stays high after the transfer so that a following point can go
    // out back to back; a gap or a drain lowers it.
    task automatic send_point(input logic [10:0] row, input logic [10:0] col);
        int gap;
        vertex_t v;
        gap = stall_free ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_vertex(row, col, v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, col, row};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        store_expected(v);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (vertex_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // Writes one register while the pipe is empty.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_RADIUS) radius_q = value;
        else if (idx == REG_SECTORS) sectors_q = value[10:0];
        else if (idx == REG_STACKS) stacks_q = value[10:0];
    endtask

    task automatic set_sphere(input logic [15:0] r, input logic [15:0] sec,
                              input logic [15:0] stk);
        write_reg(REG_RADIUS, r);
        write_reg(REG_SECTORS, sec);
        write_reg(REG_STACKS, stk);
    endtask

    // Poles, seam, extreme field values and clamping under several settings.
    task automatic test_directed;
        send_point(0, 0);
        send_point(18, 36);
        send_point(9, 9);
        send_point(9, 18);
        send_point(19, 0);
        send_point(0, 37);
        send_point(11'h7FF, 11'h7FF);
        send_point(11'h555, 11'h2AA);
        send_point(11'h2AA, 11'h555);
        set_sphere(16'd0, 16'd3, 16'd2);
        send_point(1, 1);
        send_point(2, 3);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_point(1, 2);
        set_sphere(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_point(512, 1024);
        send_point(1024, 256);
        send_point(300, 700);
        set_sphere(16'd1, 16'd1, 16'd0);
        send_point(1, 2);
        send_point(2, 4);
    endtask

    // Random points, mostly in range, over several sphere settings.
    task automatic test_random;
        int per_phase;
        logic [10:0] row, col;
        per_phase = 290;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_sphere(16'd256, 16'd36, 16'd18);
                1: set_sphere(16'($urandom), 16'($urandom_range(3, 1024)),
                              16'($urandom_range(2, 1024)));
                2: set_sphere(16'hFFFF, 16'd1024, 16'd1024);
                3: set_sphere(16'd1, 16'd3, 16'd2);
                default: set_sphere(16'($urandom), 16'($urandom_range(0, 2047)),
                                    16'($urandom_range(0, 2047)));
            endcase
            if (ph == 2) begin
                drain();
                stall_free = 1'b1;
            end
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 9) < 8) begin
                    row = 11'($urandom_range(0, 32'(limit(stacks_q, 2, MAX_COUNT_DEF))));
                    col = 11'($urandom_range(0, 32'(limit(sectors_q, 3, MAX_COUNT_DEF))));
                end else begin
                    row = 11'($urandom);
                    col = 11'($urandom);
                end
                send_point(row, col);
            end
            stall_free = 1'b0;
        end
    endtask

    // Receiver: random stall per vertex, then compares fields.
    initial begin
        int stall;
        vertex_t want;
        @(posedge aresetn);
        forever begin
            stall = stall_free ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            if (vertex_queue.size() == 0) begin
                report_mismatch("unexpected vertex", m_axis_tdata[63:0], 0);
            end else begin
                want = vertex_queue.pop_front();
                if (m_axis_tdata[16:0] != want.pos_x)
                    report_mismatch("pos_x", m_axis_tdata[16:0], want.pos_x);
                if (m_axis_tdata[33:17] != want.pos_y)
                    report_mismatch("pos_y", m_axis_tdata[33:17], want.pos_y);
                if (m_axis_tdata[50:34] != want.pos_z)
                    report_mismatch("pos_z", m_axis_tdata[50:34], want.pos_z);
                if (m_axis_tdata[66:51] != want.norm_x)
                    report_mismatch("norm_x", m_axis_tdata[66:51], want.norm_x);
                if (m_axis_tdata[82:67] != want.norm_y)
                    report_mismatch("norm_y", m_axis_tdata[82:67], want.norm_y);
                if (m_axis_tdata[98:83] != want.norm_z)
                    report_mismatch("norm_z", m_axis_tdata[98:83], want.norm_z);
                if (m_axis_tdata[115:99] != want.tex_s)
                    report_mismatch("tex_s", m_axis_tdata[115:99], want.tex_s);
                if (m_axis_tdata[132:116] != want.tex_t)
                    report_mismatch("tex_t", m_axis_tdata[132:116], want.tex_t);
                if (m_axis_tuser != want.clamped)
                    report_mismatch("index_clamped", m_axis_tuser, want.clamped);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        drain();
        if (error_count == 0 && vertex_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
